@@ rtl/glcm8_pkg.sv @@
package glcm8_pkg;

   localparam int GRAY_W      = 4;
   localparam int SIZE_W      = 11;
   localparam int CNT_W       = 21;
   localparam int VAL_W       = 41;
   localparam int SUM_W       = 2 * CNT_W + 1;
   localparam int DIR_W       = 3;
   localparam int FEAT_W      = 2;
   localparam int RES_IW      = FEAT_W + DIR_W;
   localparam int NUM_DIRS    = 8;
   localparam int NUM_RESULTS = 24;
   localparam int CSR_IDX_W   = 1;

   localparam logic [SIZE_W-1:0]    SIZE_RESET = 11'd1024;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 1'b1;

   localparam logic [FEAT_W-1:0] FEAT_CONTRAST    = 2'd0;
   localparam logic [FEAT_W-1:0] FEAT_ENERGY      = 2'd1;
   localparam logic [FEAT_W-1:0] FEAT_HOMOGENEITY = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PX_UP,
      S_PX_UR,
      S_BUMP_RD,
      S_BUMP_WR,
      S_PX_FIN,
      S_F_RD,
      S_F_LD,
      S_F_MUL,
      S_F_DIV,
      S_F_ACC,
      S_EMIT
   } state_type;

endpackage

@@ rtl/glcm8_ram.sv @@
module glcm8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/glcm8_div.sv @@
module glcm8_div #(
   parameter int DIVR_W = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [glcm8_pkg::CNT_W-1:0] dividend,
   input  logic [DIVR_W-1:0]           divisor,
   output logic                        done,
   output logic [glcm8_pkg::CNT_W-1:0] quotient
);
   import glcm8_pkg::*;

   localparam int STEP_W = $clog2(CNT_W + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  q_ff, q_in;
   logic [DIVR_W-1:0] r_ff, r_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;
   logic [DIVR_W:0]   shifted;
   logic [DIVR_W:0]   diff;
   logic              ge;

   always_comb begin
      shifted = {r_ff, q_ff[CNT_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(CNT_W);
         q_in    = dividend;
         r_in    = '0;
         dvs_in  = divisor;
      end else if (run_ff) begin
         q_in    = {q_ff[CNT_W-2:0], ge};
         r_in    = ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

@@ rtl/glcm_eight_direction_features_top.sv @@
// A pixel request keeps busy high while its four neighbour pairs are counted; each enabled
// pair takes a counter memory read and write per half, a disabled pair neither.
// A new pixel is taken only once busy falls. After the last pixel the feature pass sweeps
// all 8*4^ceil(log2(GRAY_LEVELS)) counters, each read, cleared, multiplied, divided by the
// serial divider and accumulated; then 24 results follow unbroken; the receiver cannot stall.
// Reset: synchronous; clearing all 8*4^ceil(log2(GRAY_LEVELS)) counters keeps busy high.
module glcm_eight_direction_features_top #(
   parameter int GRAY_LEVELS = 16,
   parameter int MAX_COLS    = 1024,
   parameter int MAX_ROWS    = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [glcm8_pkg::GRAY_W-1:0]    req_gray,
   output logic                            busy,
   input  logic                            csr_wr_en,
   input  logic [glcm8_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [glcm8_pkg::SIZE_W-1:0]    csr_wdata,
   output logic                            rsp_valid,
   output logic [glcm8_pkg::DIR_W-1:0]     rsp_direction,
   output logic [glcm8_pkg::FEAT_W-1:0]    rsp_feature,
   output logic [glcm8_pkg::VAL_W-1:0]     rsp_value,
   output logic                            rsp_last
);
   import glcm8_pkg::*;

   localparam int LW     = $clog2(GRAY_LEVELS);
   localparam int CELL_W = 2 * LW;
   localparam int AW     = DIR_W + CELL_W;
   localparam int CDEPTH = 1 << AW;
   localparam int CW     = $clog2(MAX_COLS);
   localparam int CNW    = CW + 1;
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int RNW    = RW + 1;
   localparam int DIV_W  = $clog2(GRAY_LEVELS + 1);
   localparam int PROD_W = CELL_W + CNT_W;

   function automatic logic [VAL_W-1:0] sat_acc(input logic [VAL_W-1:0] acc,
                                                input logic [2*CNT_W-1:0] term);
      logic [SUM_W-1:0] s;
      s = SUM_W'(acc) + SUM_W'(term);
      if (s > SUM_W'({VAL_W{1'b1}})) begin
         return {VAL_W{1'b1}};
      end
      return s[VAL_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] cols_ff, rows_ff;
   logic [CW-1:0]     col_ff;
   logic [RW-1:0]     row_ff;
   logic [LW-1:0]     left_ff, ul_ff;
   logic [LW-1:0]     v_ff, up_ff, upr_ff;
   logic [2:0]        bump_ff;
   logic [RES_IW-1:0] emit_ff;
   logic [AW-1:0]     cell_ff;

   logic [CNT_W-1:0]   cnt_ff;
   logic [LW-1:0]      dd_ff;
   logic [CELL_W-1:0]  dsq_ff;
   logic [PROD_W-1:0]  con_ff;
   logic [2*CNT_W-1:0] eng_ff;
   logic [VAL_W-1:0]   con_sum_ff, eng_sum_ff, hom_sum_ff;
   logic [VAL_W-1:0]   res_ff [NUM_RESULTS];

   logic [CNW-1:0] eff_cols, col_inc;
   logic [RNW-1:0] eff_rows, row_inc;
   logic           row_end, img_end;
   logic [3:0]     p_en;
   logic [1:0]     pj;
   logic           half;
   logic [LW-1:0]  nb, gray_sat, bx, by, fx, fy, fd;
   logic [DIR_W-1:0] bdir, fdir;
   logic [AW-1:0]  bump_addr;

   logic             row_rd_en, row_wr_en;
   logic [CW-1:0]    row_rd_addr;
   logic [LW-1:0]    row_rd_data;
   logic             cnt_rd_en, cnt_wr_en;
   logic [AW-1:0]    cnt_rd_addr, cnt_wr_addr;
   logic [CNT_W-1:0] cnt_wr_data, cnt_rd_data, cnt_inc;
   logic             div_start, div_done;
   logic [CNT_W-1:0] div_q;
   logic [VAL_W-1:0] con_new, eng_new, hom_new;

   // Effective image size and position bookkeeping.
   always_comb begin
      if (cols_ff == '0) begin
         eff_cols = CNW'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         eff_cols = CNW'(MAX_COLS);
      end else begin
         eff_cols = CNW'(cols_ff);
      end
      if (rows_ff == '0) begin
         eff_rows = RNW'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         eff_rows = RNW'(MAX_ROWS);
      end else begin
         eff_rows = RNW'(rows_ff);
      end
      col_inc = {1'b0, col_ff} + CNW'(1);
      row_inc = {1'b0, row_ff} + RNW'(1);
      row_end = col_inc >= eff_cols;
      img_end = row_end && (row_inc >= eff_rows);
      p_en[0] = (row_ff != '0) && (col_ff != '0);
      p_en[1] = (row_ff != '0);
      p_en[2] = (row_ff != '0) && (col_inc < eff_cols);
      p_en[3] = (col_ff != '0);
      gray_sat = (int'(req_gray) >= GRAY_LEVELS) ? LW'(GRAY_LEVELS - 1) : LW'(req_gray);
   end

   // Each pair is counted as (pixel, neighbour) in its own direction and reversed in
   // the opposite direction, so each bump step selects one half.
   always_comb begin
      pj   = bump_ff[2:1];
      half = bump_ff[0];
      case (pj)
         2'd0:    nb = ul_ff;
         2'd1:    nb = up_ff;
         2'd2:    nb = upr_ff;
         default: nb = left_ff;
      endcase
      bdir      = half ? ~{1'b0, pj} : {1'b0, pj};
      bx        = half ? nb : v_ff;
      by        = half ? v_ff : nb;
      bump_addr = {bdir, bx, by};
      cnt_inc   = (&cnt_rd_data) ? cnt_rd_data : cnt_rd_data + CNT_W'(1);
      fdir      = cell_ff[AW-1:CELL_W];
      fx        = cell_ff[CELL_W-1:LW];
      fy        = cell_ff[LW-1:0];
      fd        = (fx > fy) ? fx - fy : fy - fx;
      con_new   = sat_acc(con_sum_ff, (2*CNT_W)'(con_ff));
      eng_new   = sat_acc(eng_sum_ff, eng_ff);
      hom_new   = sat_acc(hom_sum_ff, (2*CNT_W)'(div_q));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:   if (&cell_ff) state_in = S_IDLE;
         S_IDLE:    if (start) state_in = S_PX_UP;
         S_PX_UP:   state_in = S_PX_UR;
         S_PX_UR:   state_in = S_BUMP_RD;
         S_BUMP_RD: begin
            if (p_en[pj]) begin
               state_in = S_BUMP_WR;
            end else if (&bump_ff) begin
               state_in = S_PX_FIN;
            end
         end
         S_BUMP_WR: state_in = (&bump_ff) ? S_PX_FIN : S_BUMP_RD;
         S_PX_FIN:  state_in = img_end ? S_F_RD : S_IDLE;
         S_F_RD:    state_in = S_F_LD;
         S_F_LD:    state_in = S_F_MUL;
         S_F_MUL:   state_in = S_F_DIV;
         S_F_DIV:   if (div_done) state_in = S_F_ACC;
         S_F_ACC:   state_in = (&cell_ff) ? S_EMIT : S_F_RD;
         S_EMIT:    if (emit_ff == RES_IW'(NUM_RESULTS - 1)) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      row_rd_en   = 1'b0;
      row_wr_en   = 1'b0;
      row_rd_addr = col_ff;
      cnt_rd_en   = 1'b0;
      cnt_wr_en   = 1'b0;
      cnt_rd_addr = bump_addr;
      cnt_wr_addr = bump_addr;
      cnt_wr_data = cnt_inc;
      div_start   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = cell_ff;
            cnt_wr_data = '0;
         end
         S_IDLE:    row_rd_en = 1'b1;
         S_PX_UP: begin
            row_rd_en   = 1'b1;
            row_wr_en   = 1'b1;
            row_rd_addr = (col_inc < CNW'(MAX_COLS)) ? col_inc[CW-1:0] : '0;
         end
         S_BUMP_RD: cnt_rd_en = p_en[pj];
         S_BUMP_WR: cnt_wr_en = 1'b1;
         S_F_RD: begin
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = cell_ff;
         end
         S_F_LD: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = cell_ff;
            cnt_wr_data = '0;
         end
         S_F_MUL:   div_start = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cols_ff  <= SIZE_RESET;
         rows_ff  <= SIZE_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
         ul_ff    <= '0;
         bump_ff  <= '0;
         emit_ff  <= '0;
         cell_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_COLS: cols_ff <= csr_wdata;
               CSR_ROWS: rows_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (state_ff == S_CLEAR || state_ff == S_F_ACC) begin
            cell_ff <= cell_ff + AW'(1);
         end
         if ((state_ff == S_BUMP_RD && !p_en[pj]) || state_ff == S_BUMP_WR) begin
            bump_ff <= bump_ff + 3'd1;
         end
         if (state_ff == S_EMIT) begin
            emit_ff <= (emit_ff == RES_IW'(NUM_RESULTS - 1)) ? '0 : emit_ff + RES_IW'(1);
         end
         if (state_ff == S_PX_FIN) begin
            if (img_end) begin
               col_ff  <= '0;
               row_ff  <= '0;
               left_ff <= '0;
               ul_ff   <= '0;
            end else begin
               left_ff <= v_ff;
               ul_ff   <= up_ff;
               if (row_end) begin
                  col_ff <= '0;
                  row_ff <= row_inc[RW-1:0];
               end else begin
                  col_ff <= col_inc[CW-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) v_ff <= gray_sat;
      if (state_ff == S_PX_UP) up_ff <= row_rd_data;
      if (state_ff == S_PX_UR) upr_ff <= row_rd_data;
      if (state_ff == S_PX_FIN) begin
         con_sum_ff <= '0;
         eng_sum_ff <= '0;
         hom_sum_ff <= '0;
      end
      if (state_ff == S_F_LD) begin
         cnt_ff <= cnt_rd_data;
         dd_ff  <= fd;
         dsq_ff <= CELL_W'(fd) * CELL_W'(fd);
      end
      if (state_ff == S_F_MUL) begin
         con_ff <= PROD_W'(dsq_ff) * PROD_W'(cnt_ff);
         eng_ff <= (2*CNT_W)'(cnt_ff) * (2*CNT_W)'(cnt_ff);
      end
      if (state_ff == S_F_ACC) begin
         if (&cell_ff[CELL_W-1:0]) begin
            res_ff[{FEAT_CONTRAST, fdir}]    <= con_new;
            res_ff[{FEAT_ENERGY, fdir}]      <= eng_new;
            res_ff[{FEAT_HOMOGENEITY, fdir}] <= hom_new;
            con_sum_ff <= '0;
            eng_sum_ff <= '0;
            hom_sum_ff <= '0;
         end else begin
            con_sum_ff <= con_new;
            eng_sum_ff <= eng_new;
            hom_sum_ff <= hom_new;
         end
      end
   end

   glcm8_ram #(.WIDTH(LW), .DEPTH(MAX_COLS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (col_ff),
      .wr_data (v_ff),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   glcm8_ram #(.WIDTH(CNT_W), .DEPTH(CDEPTH)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   glcm8_div #(.DIVR_W(DIV_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cnt_ff),
      .divisor  (DIV_W'(dd_ff) + DIV_W'(1)),
      .done     (div_done),
      .quotient (div_q)
   );

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = (state_ff == S_EMIT);
   assign rsp_direction = emit_ff[DIR_W-1:0];
   assign rsp_feature   = emit_ff[RES_IW-1:DIR_W];
   assign rsp_value     = res_ff[emit_ff];
   assign rsp_last      = rsp_valid && (emit_ff == RES_IW'(NUM_RESULTS - 1));

endmodule

@@ rtl/glcm8_checker.sv @@
module glcm8_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [glcm8_pkg::DIR_W-1:0] rsp_direction,
   input logic                        rsp_last
);
   import glcm8_pkg::*;

   // Results are only shown while the block is busy.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid)
      else $error("last flag without a result");

   // The 24 results form one unbroken burst.
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("result burst broken");

   a_dir_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_direction == DIR_W'($past(rsp_direction) + 1)))
      else $error("direction sequence broken");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

endmodule

bind glcm_eight_direction_features_top glcm8_checker u_glcm8_checker (.*);
